// File: rtl/cpq_pkg.sv
// Shared types, constants and helpers for the PCM sample queue pair.
`default_nettype none
package cpq_pkg;

  localparam int BLOCK_SAMPLES = 160;
  localparam int MIC_INPUTS    = 3;
  localparam int OUT_CHANNELS  = 2;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 11;
  localparam int COUNT_W  = 16;
  localparam int BITS_W   = 5;
  localparam int ROUTE_W  = 2;
  localparam int GAIN_W   = 16;
  localparam int FUNC_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 120;
  localparam int M_TUSER_W = 2;

  // item kinds
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONVERTER_BITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIC_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIC_ROUTE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROUTE      = 3'd4;

  localparam logic [BITS_W-1:0] BITS_RESET = 5'd16;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [SAMPLE_W-1:0] data;
  } cpq_fifo_op_t;

  // converter widths outside 2..16 act as 16
  function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] v);
    logic [BITS_W-1:0] r;
    r = (v >= 5'd2 && v <= 5'd16) ? v : 5'd16;
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cpq_fifo.sv
// Circular sample queue: one synchronous memory with head and fill tracking.
`default_nettype none
module cpq_fifo
  import cpq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rd_en,
  output logic [SAMPLE_W-1:0]                 rd_data,
  input  wire cpq_fifo_op_t                   op,
  output logic [$clog2(DEPTH+1)-1:0]          fill,
  output logic                                full
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [FW:0]   DEPTH_V = (FW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_V  = AW'(DEPTH - 1);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [AW-1:0]       head;
  logic [AW-1:0]       head_inc;
  logic [FW:0]         tail_sum;
  logic [AW-1:0]       tail;

  assign full     = (fill == DEPTH_V[FW-1:0]);
  assign head_inc = (head == LAST_V) ? '0 : head + 1'b1;

  always_comb begin
    tail_sum = (FW+1)'(head) + {1'b0, fill};
    if (tail_sum >= DEPTH_V) begin
      tail_sum = tail_sum - DEPTH_V;
    end
    tail = tail_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[head];
    end
    if (op.push) begin
      mem[tail] <= op.data;
    end
  end

  // a push into a full queue overwrites the oldest entry and advances head
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (op.push) begin
      if (full) begin
        head <= head_inc;
      end else begin
        fill <= fill + 1'b1;
      end
    end else if (op.pop) begin
      head <= head_inc;
      fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cpq_mic_scale.sv
// Microphone gain, scaling to converter width with truncation, and clamp.
`default_nettype none
module cpq_mic_scale
  import cpq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic signed [SAMPLE_W-1:0] level,
  input  wire logic [GAIN_W-1:0]          gain,
  input  wire logic [BITS_W-1:0]          bits,
  output logic [SAMPLE_W-1:0]             sample
);

  logic signed [32:0] prod;
  logic [BITS_W-1:0]  sh;
  logic signed [32:0] bias;
  logic signed [32:0] shifted;
  logic signed [32:0] lim;
  logic signed [32:0] clamped;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= level * $signed({1'b0, gain});
    end
  end

  always_comb begin
    sh      = 5'd28 - bits;
    bias    = $signed((33'd1 << sh) - 33'd1);
    // round negative values toward zero before the arithmetic shift
    shifted = (prod[32] ? prod + bias : prod) >>> sh;
    lim     = $signed(33'd1 << (bits - 5'd1));
    if (shifted < -lim) begin
      clamped = -lim;
    end else if (shifted > lim - 33'sd1) begin
      clamped = lim - 33'sd1;
    end else begin
      clamped = shifted;
    end
    sample = clamped[SAMPLE_W-1:0];
  end

endmodule
`default_nettype wire

// File: rtl/cpq_out_scale.sv
// Earpiece output scaling, gain and saturation to Q1.15.
`default_nettype none
module cpq_out_scale
  import cpq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [GAIN_W-1:0]          gain,
  input  wire logic [BITS_W-1:0]          bits,
  output logic signed [SAMPLE_W-1:0]      level
);

  logic [29:0]        gain_sh;
  logic signed [46:0] prod;
  logic signed [46:0] shifted;

  // fold the converter scale into the gain so one multiply covers both
  assign gain_sh = 30'(gain) << (5'd16 - bits);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= sample * $signed({1'b0, gain_sh});
    end
  end

  always_comb begin
    shifted = (prod[46] ? prod + 47'sd4095 : prod) >>> 12;
    if (shifted > 47'sd32767) begin
      level = 16'sh7FFF;
    end else if (shifted < -47'sd32768) begin
      level = 16'sh8000;
    end else begin
      level = shifted[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/codec_pcm_sample_queues_core.sv
// Usage: PCM sample queue pair between a DSP and the audio converters.
// Input stream (s_*): one item per transaction; s_tuser[1:0] selects a converter
//   tick, an earpiece sample write or a microphone sample read, s_tuser[2] and
//   s_tlast mark the first and last sample of a block. s_tdata carries the
//   earpiece sample and the three microphone levels.
// Output stream (m_*): exactly one result transaction per input transaction,
//   in order, with output levels, the popped microphone sample, status flags,
//   both queue fills and the saturating error counters.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle;
//   write only while no item is in flight.
// Result path: an item goes through the execute and final steps into the
//   output register; no new item is taken before the last reaches its final
//   step, set by the queue memory read at acceptance and write the next cycle.
// Stall: a held result keeps the block in its final step, where no new item
//   is taken until the output register can load.
// Reset: both queues empty, counters zero, registers at their defaults; the
//   queue memories are not cleared and need no startup pass.
`default_nettype none
module codec_pcm_sample_queues_core
  import cpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // pcm_sample, mic_in_0, mic_in_1, mic_in_2
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // func, block_first
  input  wire logic [S_TUSER_W-1:0]  s_tuser,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // audio_out_0, audio_out_1, mic_sample, ear_level, mic_level,
  // ear_overrun_total, mic_overrun_total, mic_underrun_total, zero fill
  output logic [M_TDATA_W-1:0]       m_tdata,
  // mic_underrun, block_refused
  output logic [M_TUSER_W-1:0]       m_tuser,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [BITS_W-1:0]  converter_bits;
  logic [GAIN_W-1:0]  mic_gain;
  logic [GAIN_W-1:0]  out_gain;
  logic [ROUTE_W-1:0] mic_route;
  logic [ROUTE_W-1:0] out_route;
  logic [BITS_W-1:0]  bits;

  logic [FUNC_W-1:0]   func_q;
  logic                first_q;
  logic                last_q;
  logic [SAMPLE_W-1:0] pcm_q;

  logic               dropping_block;
  logic [COUNT_W-1:0] ear_overruns;
  logic [COUNT_W-1:0] mic_overruns;
  logic [COUNT_W-1:0] mic_underruns;

  logic                pend_tick;
  logic [SAMPLE_W-1:0] pend_msamp;
  logic                pend_underrun;
  logic                pend_refused;

  logic accept;
  logic out_free;
  logic out_load;

  cpq_fifo_op_t        ear_op;
  cpq_fifo_op_t        mic_op;
  logic [SAMPLE_W-1:0] ear_rd_data;
  logic [SAMPLE_W-1:0] mic_rd_data;
  logic [FW-1:0]       ear_fill;
  logic [FW-1:0]       mic_fill;
  logic                ear_full;
  logic                mic_full;

  logic signed [SAMPLE_W-1:0] mic_level_in;
  logic [SAMPLE_W-1:0]        mic_push_data;
  logic signed [SAMPLE_W-1:0] ear_sample;
  logic signed [SAMPLE_W-1:0] out_level;

  logic refuse_now;
  logic dropping_eff;
  logic [SAMPLE_W-1:0] audio_0;
  logic [SAMPLE_W-1:0] audio_1;

  assign bits     = eff_bits(converter_bits);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) || (state == ST_FIN && out_free);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_FIN) && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      converter_bits <= BITS_RESET;
      mic_gain       <= GAIN_UNITY;
      out_gain       <= GAIN_UNITY;
      mic_route      <= '0;
      out_route      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CONVERTER_BITS: converter_bits <= cfg_data[BITS_W-1:0];
        REG_MIC_GAIN:       mic_gain       <= cfg_data[GAIN_W-1:0];
        REG_OUT_GAIN:       out_gain       <= cfg_data[GAIN_W-1:0];
        REG_MIC_ROUTE:      mic_route      <= cfg_data[ROUTE_W-1:0];
        REG_OUT_ROUTE:      out_route      <= cfg_data[ROUTE_W-1:0];
        default: ;
      endcase
    end
  end

  // microphone input routing
  always_comb begin
    mic_level_in = '0;
    if (32'(mic_route) < 32'(MIC_INPUTS)) begin
      unique case (mic_route)
        2'd0:    mic_level_in = $signed(s_tdata[31:16]);
        2'd1:    mic_level_in = $signed(s_tdata[47:32]);
        2'd2:    mic_level_in = $signed(s_tdata[63:48]);
        default: mic_level_in = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= s_tuser[FUNC_W-1:0];
      first_q <= s_tuser[2];
      last_q  <= s_tlast;
      pcm_q   <= s_tdata[15:0];
    end
  end

  cpq_mic_scale u_mic_scale (
    .clk    (clk),
    .load   (accept),
    .level  (mic_level_in),
    .gain   (mic_gain),
    .bits   (bits),
    .sample (mic_push_data)
  );

  // queue operations, decided in the write-back step
  always_comb begin
    refuse_now   = first_q &&
                   (32'(ear_fill) + 32'(BLOCK_SAMPLES) > 32'(QUEUE_DEPTH));
    dropping_eff = first_q ? refuse_now : dropping_block;
    ear_op       = '{push: 1'b0, pop: 1'b0, data: pcm_q};
    mic_op       = '{push: 1'b0, pop: 1'b0, data: mic_push_data};
    ear_sample   = '0;
    if (state == ST_EXEC) begin
      unique case (func_q)
        FUNC_TICK: begin
          mic_op.push = 1'b1;
          if (ear_fill != '0) begin
            ear_op.pop = 1'b1;
            ear_sample = $signed(ear_rd_data);
          end
        end
        FUNC_WRITE: begin
          ear_op.push = !dropping_eff && !ear_full;
        end
        FUNC_READ: begin
          mic_op.pop = (mic_fill != '0);
        end
        default: ;
      endcase
    end
  end

  cpq_fifo #(.DEPTH(QUEUE_DEPTH)) u_ear_fifo (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_data (ear_rd_data),
    .op      (ear_op),
    .fill    (ear_fill),
    .full    (ear_full)
  );

  cpq_fifo #(.DEPTH(QUEUE_DEPTH)) u_mic_fifo (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_data (mic_rd_data),
    .op      (mic_op),
    .fill    (mic_fill),
    .full    (mic_full)
  );

  cpq_out_scale u_out_scale (
    .clk    (clk),
    .load   (state == ST_EXEC),
    .sample (ear_sample),
    .gain   (out_gain),
    .bits   (bits),
    .level  (out_level)
  );

  // block admission state, counters and per-item result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      dropping_block <= 1'b0;
      ear_overruns   <= '0;
      mic_overruns   <= '0;
      mic_underruns  <= '0;
    end else if (state == ST_EXEC) begin
      unique case (func_q)
        FUNC_TICK: begin
          if (mic_full) begin
            mic_overruns <= sat_inc(mic_overruns);
          end
        end
        FUNC_WRITE: begin
          if (refuse_now) begin
            ear_overruns <= sat_inc(ear_overruns);
          end
          dropping_block <= last_q ? 1'b0 : dropping_eff;
        end
        FUNC_READ: begin
          if (mic_fill == '0) begin
            mic_underruns <= sat_inc(mic_underruns);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      pend_tick     <= (func_q == FUNC_TICK);
      pend_msamp    <= (func_q == FUNC_READ && mic_fill != '0) ? mic_rd_data : '0;
      pend_underrun <= (func_q == FUNC_READ && mic_fill == '0);
      pend_refused  <= (func_q == FUNC_WRITE && dropping_eff);
    end
  end

  always_comb begin
    audio_0 = '0;
    audio_1 = '0;
    if (pend_tick) begin
      if (out_route == 2'd0 && OUT_CHANNELS > 0) begin
        audio_0 = out_level;
      end
      if (out_route == 2'd1 && OUT_CHANNELS > 1) begin
        audio_1 = out_level;
      end
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = accept ? ST_EXEC : ST_IDLE;
        end else begin
          state_next = ST_FIN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, mic_underruns, mic_overruns, ear_overruns,
                  LEVEL_W'(mic_fill), LEVEL_W'(ear_fill),
                  pend_msamp, audio_1, audio_0};
      m_tuser <= {pend_refused, pend_underrun};
    end
  end

endmodule
`default_nettype wire

// File: test/pcm_queue_checker.sv
// Checker for the PCM sample queue pair: predicts each result and compares it on the output stream.
`timescale 1ns / 100ps
module pcm_queue_checker
  import cpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  // pcm_sample, mic_in_0, mic_in_1, mic_in_2
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // func, block_first
  input  wire logic [S_TUSER_W-1:0]  s_tuser,
  input  wire logic                  s_tlast,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  // audio_out_0, audio_out_1, mic_sample, ear_level, mic_level,
  // ear_overrun_total, mic_overrun_total, mic_underrun_total, zero fill
  input  wire logic [M_TDATA_W-1:0]  m_tdata,
  // mic_underrun, block_refused
  input  wire logic [M_TUSER_W-1:0]  m_tuser,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         errors,
  output int                         results_owed
);

  typedef struct {
    logic [15:0] out0;
    logic [15:0] out1;
    logic [15:0] mic_pop;
    logic        starved;
    logic        refused;
    logic [10:0] ear_fill;
    logic [10:0] mic_fill;
    logic [15:0] ear_refusals;
    logic [15:0] mic_drops;
    logic [15:0] mic_starves;
  } queue_result_t;

  // register copies
  logic [BITS_W-1:0]  conv_bits;
  logic [GAIN_W-1:0]  mic_gain_r;
  logic [GAIN_W-1:0]  out_gain_r;
  logic [ROUTE_W-1:0] mic_sel;
  logic [ROUTE_W-1:0] out_sel;

  // queue state
  logic [15:0] ear_mem [QUEUE_DEPTH];
  logic [15:0] mic_mem [QUEUE_DEPTH];
  int          ear_rd, ear_cnt, mic_rd, mic_cnt;
  logic        skipping;
  logic [15:0] ear_refusals, mic_drops, mic_starves;

  queue_result_t pending_results[$];
  queue_result_t fresh, want;
  int            result_no;

  initial begin
    errors = 0;
    results_owed = 0;
    result_no = 0;
  end

  function automatic logic [15:0] saturating_add1(input logic [15:0] c);
    return (c == 16'hffff) ? c : c + 16'd1;
  endfunction

  function automatic longint shift_toward_zero(input longint v, input int unsigned sh);
    return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
    if (errors < 100)
      $display("result %0d: %s expected %h got %h", result_no, what, exp_v, got_v);
    errors++;
  endtask

  task automatic advance_queues(input logic [1:0] kind, input logic [15:0] pcm,
                                input logic first, input logic last_mark,
                                input logic [47:0] mic_levels, output queue_result_t r);
    int unsigned width;
    longint      scale, lvl, q, e, y;
    r = '{default: '0};
    width = (conv_bits >= 5'd2 && conv_bits <= 5'd16) ? 32'(conv_bits) : 32'd16;
    case (kind)
      FUNC_TICK: begin
        scale = longint'(1) << (width - 1);
        // make room by dropping the oldest capture sample
        if (mic_cnt >= QUEUE_DEPTH) begin
          mic_rd = (mic_rd + 1) % QUEUE_DEPTH;
          mic_cnt = QUEUE_DEPTH - 1;
          mic_drops = saturating_add1(mic_drops);
        end
        lvl = 0;
        if (mic_sel < MIC_INPUTS)
          lvl = longint'($signed(mic_levels[16*mic_sel +: 16]));
        q = clip(shift_toward_zero(lvl * longint'(mic_gain_r), 28 - width), -scale, scale - 1);
        mic_mem[(mic_rd + mic_cnt) % QUEUE_DEPTH] = q[15:0];
        mic_cnt++;
        e = 0;
        if (ear_cnt > 0) begin
          e = longint'($signed(ear_mem[ear_rd]));
          ear_rd = (ear_rd + 1) % QUEUE_DEPTH;
          ear_cnt--;
        end
        y = e * longint'(out_gain_r) * (longint'(1) << (16 - width));
        y = clip(shift_toward_zero(y, 12), -32768, 32767);
        if (out_sel == 2'd0)
          r.out0 = y[15:0];
        else if (out_sel == 2'd1)
          r.out1 = y[15:0];
      end
      FUNC_WRITE: begin
        // admission is decided once per block, on its first sample
        if (first) begin
          if (ear_cnt + BLOCK_SAMPLES > QUEUE_DEPTH) begin
            skipping = 1'b1;
            ear_refusals = saturating_add1(ear_refusals);
          end else begin
            skipping = 1'b0;
          end
        end
        if (skipping) begin
          r.refused = 1'b1;
        end else if (ear_cnt < QUEUE_DEPTH) begin
          ear_mem[(ear_rd + ear_cnt) % QUEUE_DEPTH] = pcm;
          ear_cnt++;
        end
        if (last_mark)
          skipping = 1'b0;
      end
      FUNC_READ: begin
        if (mic_cnt > 0) begin
          r.mic_pop = mic_mem[mic_rd];
          mic_rd = (mic_rd + 1) % QUEUE_DEPTH;
          mic_cnt--;
        end else begin
          r.starved = 1'b1;
          mic_starves = saturating_add1(mic_starves);
        end
      end
      default: ;
    endcase
    r.ear_fill = ear_cnt[10:0];
    r.mic_fill = mic_cnt[10:0];
    r.ear_refusals = ear_refusals;
    r.mic_drops = mic_drops;
    r.mic_starves = mic_starves;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      conv_bits = BITS_RESET;
      mic_gain_r = GAIN_UNITY;
      out_gain_r = GAIN_UNITY;
      mic_sel = '0;
      out_sel = '0;
      ear_rd = 0;
      ear_cnt = 0;
      mic_rd = 0;
      mic_cnt = 0;
      skipping = 1'b0;
      ear_refusals = '0;
      mic_drops = '0;
      mic_starves = '0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CONVERTER_BITS: conv_bits = cfg_data[BITS_W-1:0];
          REG_MIC_GAIN:       mic_gain_r = cfg_data;
          REG_OUT_GAIN:       out_gain_r = cfg_data;
          REG_MIC_ROUTE:      mic_sel = cfg_data[ROUTE_W-1:0];
          REG_OUT_ROUTE:      out_sel = cfg_data[ROUTE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        advance_queues(s_tuser[1:0], s_tdata[15:0], s_tuser[2], s_tlast, s_tdata[63:16],
                       fresh);
        pending_results.push_back(fresh);
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 16'h0, 16'h0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[15:0] !== want.out0)
            report_mismatch("audio_out_0", want.out0, m_tdata[15:0]);
          if (m_tdata[31:16] !== want.out1)
            report_mismatch("audio_out_1", want.out1, m_tdata[31:16]);
          if (m_tdata[47:32] !== want.mic_pop)
            report_mismatch("mic_sample", want.mic_pop, m_tdata[47:32]);
          if (m_tdata[58:48] !== want.ear_fill)
            report_mismatch("ear_level", 16'(want.ear_fill), 16'(m_tdata[58:48]));
          if (m_tdata[69:59] !== want.mic_fill)
            report_mismatch("mic_level", 16'(want.mic_fill), 16'(m_tdata[69:59]));
          if (m_tdata[85:70] !== want.ear_refusals)
            report_mismatch("ear_overrun_total", want.ear_refusals, m_tdata[85:70]);
          if (m_tdata[101:86] !== want.mic_drops)
            report_mismatch("mic_overrun_total", want.mic_drops, m_tdata[101:86]);
          if (m_tdata[117:102] !== want.mic_starves)
            report_mismatch("mic_underrun_total", want.mic_starves, m_tdata[117:102]);
          if (m_tuser[0] !== want.starved)
            report_mismatch("mic_underrun", 16'(want.starved), 16'(m_tuser[0]));
          if (m_tuser[1] !== want.refused)
            report_mismatch("block_refused", 16'(want.refused), 16'(m_tuser[1]));
        end
        result_no++;
      end
    end
    results_owed <= pending_results.size();
  end

endmodule

// File: test/codec_pcm_sample_queues_core_test.sv
// Testbench top for the PCM sample queue pair: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module codec_pcm_sample_queues_core_test;
  import cpq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // pcm_sample, mic_in_0, mic_in_1, mic_in_2
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  // func, block_first
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // audio_out_0, audio_out_1, mic_sample, ear_level, mic_level,
  // ear_overrun_total, mic_overrun_total, mic_underrun_total, zero fill
  logic [M_TDATA_W-1:0]  m_tdata;
  // mic_underrun, block_refused
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   errors;
  int   results_owed;
  int   items_taken = 0;
  int   cycles = 0;
  logic calm = 1'b0;
  logic hold_start = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  codec_pcm_sample_queues_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcm_queue_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen <= hold_start;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  function automatic logic [15:0] rand_level();
    logic [15:0] v;
    v = 16'($urandom());
    case ($urandom_range(15))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = 16'h0000;
      3: v = 16'hffff;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [FUNC_W-1:0] rand_kind();
    return FUNC_W'($urandom_range(3));
  endfunction

  task automatic offer(input logic [FUNC_W-1:0] kind, input logic [15:0] pcm,
                       input logic first, input logic last_mark,
                       input logic [15:0] mic0, input logic [15:0] mic1,
                       input logic [15:0] mic2);
    while (!calm && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {mic2, mic1, mic0, pcm};
    s_tuser <= {first, kind};
    s_tlast <= last_mark;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_taken++;
  endtask

  task automatic offer_rand(input logic [FUNC_W-1:0] kind, input logic first,
                            input logic last_mark);
    offer(kind, rand_level(), first, last_mark, rand_level(), rand_level(), rand_level());
  endtask

  // one earpiece block; now and then a first or last mark is flipped
  task automatic write_block(input int len);
    logic first, last_mark;
    for (int i = 0; i < len; i++) begin
      first = (i == 0);
      last_mark = (i == len - 1);
      if ($urandom_range(49) == 0)
        first = ~first;
      if ($urandom_range(49) == 0)
        last_mark = ~last_mark;
      offer_rand(FUNC_WRITE, first, last_mark);
    end
  endtask

  // drop valid and hold until every outstanding result has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [BITS_W-1:0]  bits_v;
    logic [GAIN_W-1:0]  micg_v, outg_v;
    logic [ROUTE_W-1:0] mroute_v, oroute_v;
    int                 target, len, pick, v;
    logic               paused;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: underrun, extremes through both queues, unused code,
    // block continuation without a first mark
    offer(FUNC_READ, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    offer(FUNC_TICK, 16'h0000, 1'b0, 1'b0, 16'h7fff, 16'h1234, 16'h8000);
    offer(FUNC_TICK, 16'hffff, 1'b1, 1'b1, 16'h8000, 16'h7fff, 16'h0000);
    offer(FUNC_TICK, 16'h0000, 1'b0, 1'b0, 16'hffff, 16'h8000, 16'h7fff);
    offer(FUNC_READ, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    offer(FUNC_READ, 16'hffff, 1'b1, 1'b1, 16'hffff, 16'hffff, 16'hffff);
    offer(FUNC_UNUSED, 16'hffff, 1'b1, 1'b1, 16'hffff, 16'hffff, 16'hffff);
    offer(FUNC_WRITE, 16'h7fff, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    offer(FUNC_WRITE, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    offer(FUNC_WRITE, 16'h0001, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    offer(FUNC_WRITE, 16'hffff, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    repeat (5) offer(FUNC_TICK, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'hffff, 16'h0000);
    offer(FUNC_WRITE, 16'h5555, 1'b1, 1'b1, 16'haaaa, 16'h5555, 16'haaaa);
    repeat (3) offer(FUNC_READ, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      calm <= (phase == 1);
      case (phase)
        0: begin
          bits_v = BITS_RESET; micg_v = GAIN_UNITY; outg_v = GAIN_UNITY;
          mroute_v = 2'd0; oroute_v = 2'd0;
        end
        1: begin
          bits_v = 5'd2; micg_v = 16'hffff; outg_v = 16'hffff;
          mroute_v = 2'd1; oroute_v = 2'd1;
        end
        2: begin
          bits_v = BITS_W'($urandom_range(15, 3));
          micg_v = GAIN_W'($urandom()); outg_v = GAIN_W'($urandom());
          mroute_v = 2'd2; oroute_v = 2'd2;
        end
        3: begin
          // widths outside the legal range
          v = $urandom_range(16);
          bits_v = BITS_W'((v < 2) ? v : v + 15);
          micg_v = 16'h0000; outg_v = 16'h0000;
          mroute_v = 2'd3; oroute_v = 2'd3;
        end
        4: begin
          bits_v = 5'd15; micg_v = GAIN_W'($urandom()); outg_v = GAIN_W'($urandom());
          mroute_v = ROUTE_W'($urandom_range(3)); oroute_v = ROUTE_W'($urandom_range(3));
        end
        default: begin
          bits_v = BITS_W'($urandom_range(31));
          micg_v = GAIN_W'($urandom()); outg_v = GAIN_W'($urandom());
          mroute_v = ROUTE_W'($urandom_range(3)); oroute_v = ROUTE_W'($urandom_range(3));
        end
      endcase
      for (int ri = REG_CONVERTER_BITS; ri <= REG_OUT_ROUTE; ri++) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(ri);
        case (ri)
          REG_CONVERTER_BITS: cfg_data <= {{(CFG_DATA_W-BITS_W){1'b0}}, bits_v};
          REG_MIC_GAIN:       cfg_data <= micg_v;
          REG_OUT_GAIN:       cfg_data <= outg_v;
          REG_MIC_ROUTE:      cfg_data <= {{(CFG_DATA_W-ROUTE_W){1'b0}}, mroute_v};
          default:            cfg_data <= {{(CFG_DATA_W-ROUTE_W){1'b0}}, oroute_v};
        endcase
        @(posedge clk);
      end
      cfg_wr_en <= 1'b0;

      case (phase)
        0, 1: begin
          // playback build-up: blocks outpace ticks until admission refuses
          for (int round = 0; round < 4; round++) begin
            pick = $urandom_range(7);
            len = BLOCK_SAMPLES;
            if (pick == 0)
              len = $urandom_range(20, 1);
            else if (pick <= 2)
              len = $urandom_range(BLOCK_SAMPLES + 100, BLOCK_SAMPLES + 1);
            // overlong block to run the earpiece queue full
            if (phase == 1 && round == 1)
              len = 260;
            write_block(len);
            repeat ($urandom_range(6)) offer_rand(FUNC_TICK, rand_bit(), rand_bit());
            repeat ($urandom_range(3)) offer_rand(FUNC_READ, rand_bit(), rand_bit());
            if ($urandom_range(2) == 0)
              offer_rand(rand_kind(), rand_bit(), rand_bit());
          end
        end
        2, 3: begin
          // capture: ticks dominate until the microphone queue overflows
          if (phase == 2)
            hold_start <= ~hold_start;
          target = items_taken + 550;
          while (items_taken < target) begin
            pick = $urandom_range(99);
            if (pick < 94)
              offer_rand(FUNC_TICK, rand_bit(), rand_bit());
            else if (pick < 96)
              offer_rand(FUNC_READ, rand_bit(), rand_bit());
            else if (pick < 98)
              offer_rand(rand_kind(), rand_bit(), rand_bit());
            else
              write_block($urandom_range(8, 1));
          end
        end
        default: begin
          target = items_taken + 130;
          paused = 1'b0;
          while (items_taken < target) begin
            case ($urandom_range(3))
              0: repeat ($urandom_range(40, 1))
                   offer_rand(FUNC_READ, rand_bit(), rand_bit());
              1: repeat ($urandom_range(12, 1))
                   offer_rand(FUNC_TICK, rand_bit(), rand_bit());
              2: write_block(($urandom_range(2) == 0) ? BLOCK_SAMPLES : $urandom_range(20, 1));
              default: offer_rand(rand_kind(), rand_bit(), rand_bit());
            endcase
            if (phase == 4 && !paused && items_taken >= target - 65) begin
              settle();
              paused = 1'b1;
            end
          end
        end
      endcase
    end

    settle();
    if (errors == 0 && results_owed == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/cpq_pkg.sv
rtl/cpq_fifo.sv
rtl/cpq_mic_scale.sv
rtl/cpq_out_scale.sv
rtl/codec_pcm_sample_queues_core.sv
test/pcm_queue_checker.sv
test/codec_pcm_sample_queues_core_test.sv
